### rtl/core/xcs_pkg.sv
// shared types, constants and round schedule for the xtea counter-mode stream cipher
package xcs_pkg;

   localparam int ROUNDS      = 32;
   localparam int HALF_STAGES = 2 * ROUNDS;

   localparam logic [31:0] XTEA_DELTA = 32'h9e3779b9;

   localparam int KEY_WORDS  = 4;
   localparam int ADDR_WIDTH = 4;

   // register indexes of the configuration port
   typedef enum logic [1:0] {
      REG_KEY_WORD0 = 2'd0,
      REG_KEY_WORD1 = 2'd1,
      REG_KEY_WORD2 = 2'd2,
      REG_KEY_WORD3 = 2'd3
   } reg_index_type;

   typedef logic [KEY_WORDS-1:0][31:0] key_type;

   // one word moving down the cell row: cipher state of both pairs plus the data byte
   typedef struct packed {
      logic             valid;
      logic             start;
      logic             last;
      logic [3:0]       pos;
      logic [7:0]       data;
      logic [3:0][31:0] w;
   } cell_type;

   // running sum seen by half-round h (the odd half uses the sum after the increment)
   function automatic logic [31:0] half_sum(input int h);
      logic [63:0] prod;
      prod = 64'((h + 1) / 2) * 64'(XTEA_DELTA);
      return prod[31:0];
   endfunction

   // key word select for half-round h
   function automatic logic [1:0] half_sel(input int h);
      logic [31:0] s;
      s = half_sum(h);
      if ((h % 2) == 0) begin
         return s[1:0];
      end else begin
         return s[12:11];
      end
   endfunction

endpackage

### rtl/core/xcs_cell.sv
// one xtea half-round cell: updates the first word of each pair and swaps the pair
module xcs_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [31:0]       sum_in,
   input  logic [1:0]        sel_in,
   input  xcs_pkg::key_type  key_in,
   input  xcs_pkg::cell_type in_cell,
   output xcs_pkg::cell_type out_cell
);

   logic              valid_ff;
   logic              valid_in;
   xcs_pkg::cell_type word_ff;
   xcs_pkg::cell_type word_in;

   logic [31:0] round_key;
   logic [31:0] mix0;
   logic [31:0] mix1;

   always_comb begin
      round_key = sum_in + key_in[sel_in];
      mix0 = ((in_cell.w[1] << 4) ^ (in_cell.w[1] >> 5)) + in_cell.w[1];
      mix1 = ((in_cell.w[3] << 4) ^ (in_cell.w[3] >> 5)) + in_cell.w[3];

      word_in = in_cell;
      // pair swap so the next cell always updates word 0 of each pair
      word_in.w[0] = in_cell.w[1];
      word_in.w[1] = in_cell.w[0] + (mix0 ^ round_key);
      word_in.w[2] = in_cell.w[3];
      word_in.w[3] = in_cell.w[2] + (mix1 ^ round_key);

      valid_in = valid_ff;
      if (advance) begin
         valid_in = in_cell.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
      end
   end

   always_comb begin
      out_cell       = word_ff;
      out_cell.valid = valid_ff;
   end

endmodule

### rtl/core/xcs_csr.sv
// apb-style key register file
module xcs_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [xcs_pkg::ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready,
   output xcs_pkg::key_type               key_out
);

   xcs_pkg::key_type      key_ff;
   xcs_pkg::key_type      key_in;
   xcs_pkg::reg_index_type reg_index;
   logic                  write_en;

   assign csr_pready = 1'b1;
   assign reg_index  = xcs_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      key_in = key_ff;
      if (write_en) begin
         case (reg_index)
            xcs_pkg::REG_KEY_WORD0: key_in[0] = csr_pwdata;
            xcs_pkg::REG_KEY_WORD1: key_in[1] = csr_pwdata;
            xcs_pkg::REG_KEY_WORD2: key_in[2] = csr_pwdata;
            xcs_pkg::REG_KEY_WORD3: key_in[3] = csr_pwdata;
            default: key_in = key_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         xcs_pkg::REG_KEY_WORD0: csr_prdata = key_ff[0];
         xcs_pkg::REG_KEY_WORD1: csr_prdata = key_ff[1];
         xcs_pkg::REG_KEY_WORD2: csr_prdata = key_ff[2];
         xcs_pkg::REG_KEY_WORD3: csr_prdata = key_ff[3];
         default: csr_prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key_out = key_ff;

endmodule

### rtl/core/xtea_ctr_stream_cipher_unit.sv
// top level of the xtea counter-mode stream cipher
// Each packet byte is XORed with one keystream byte; encryption and decryption are the
// same. A new counter block (frame number, block index, zeros) is started at every
// sixteenth byte of a packet and travels down a row of 2*ROUNDS half-round cells (64 at
// 32 rounds) next to the byte that opened it, so each byte takes one cell per cycle and
// the block sustains one word per cycle while rsp_ready is high. A word passes the cell row,
// then the output register, before response valid rises. The key is read by every cell, so
// the user must write it only while no word is in flight; the block does not enforce this.
module xtea_ctr_stream_cipher_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic [15:0]                    req_frame_number,
   input  logic                           req_last_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_out_last,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [xcs_pkg::ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   xcs_pkg::key_type key;

   xcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .key_out     (key)
   );

   // packet counters
   logic [3:0]  byte_pos_ff;
   logic [3:0]  byte_pos_in;
   logic [31:0] block_idx_ff;
   logic [31:0] block_idx_in;
   logic [15:0] frame_ff;
   logic [15:0] frame_in;
   logic        mid_packet_ff;
   logic        mid_packet_in;

   logic        advance;
   logic        accept;
   logic [3:0]  pos_now;
   logic [31:0] blk_now;
   logic [15:0] frame_now;

   xcs_pkg::cell_type head_cell;
   xcs_pkg::cell_type chain [0:xcs_pkg::HALF_STAGES];

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [7:0]  rsp_byte_ff;
   logic [7:0]  rsp_byte_in;
   logic        rsp_last_ff;
   logic        rsp_last_in;

   logic [15:0][7:0] ks_buf_ff;
   logic [15:0][7:0] ks_buf_in;
   logic [15:0][7:0] ks_now;

   // the whole row moves together whenever the output register can take a word
   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid & advance;

   always_comb begin
      pos_now   = mid_packet_ff ? byte_pos_ff  : 4'd0;
      blk_now   = mid_packet_ff ? block_idx_ff : 32'd0;
      frame_now = mid_packet_ff ? frame_ff     : req_frame_number;

      head_cell.valid = req_valid;
      head_cell.start = (pos_now == 4'd0);
      head_cell.last  = req_last_byte;
      head_cell.pos   = pos_now;
      head_cell.data  = req_data_byte;
      head_cell.w[0]  = {frame_now, blk_now[31:16]};
      head_cell.w[1]  = {blk_now[15:0], 16'h0000};
      head_cell.w[2]  = 32'h0;
      head_cell.w[3]  = 32'h0;

      byte_pos_in   = byte_pos_ff;
      block_idx_in  = block_idx_ff;
      frame_in      = frame_ff;
      mid_packet_in = mid_packet_ff;
      if (accept) begin
         frame_in = frame_now;
         if (req_last_byte) begin
            byte_pos_in   = 4'd0;
            block_idx_in  = 32'd0;
            mid_packet_in = 1'b0;
         end else begin
            byte_pos_in   = pos_now + 4'd1;
            block_idx_in  = (pos_now == 4'd15) ? blk_now + 32'd1 : blk_now;
            mid_packet_in = 1'b1;
         end
      end
   end

   assign chain[0] = head_cell;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff   <= 4'd0;
         block_idx_ff  <= 32'd0;
         frame_ff      <= 16'd0;
         mid_packet_ff <= 1'b0;
      end else begin
         byte_pos_ff   <= byte_pos_in;
         block_idx_ff  <= block_idx_in;
         frame_ff      <= frame_in;
         mid_packet_ff <= mid_packet_in;
      end
   end

   genvar h;
   generate
      for (h = 0; h < xcs_pkg::HALF_STAGES; h++) begin : g_cell
         xcs_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .sum_in   (xcs_pkg::half_sum(h)),
            .sel_in   (xcs_pkg::half_sel(h)),
            .key_in   (key),
            .in_cell  (chain[h]),
            .out_cell (chain[h+1])
         );
      end
   endgenerate

   // a block-opening word brings its fresh keystream; later words use the buffer
   always_comb begin
      ks_now       = chain[xcs_pkg::HALF_STAGES].start ?
                     chain[xcs_pkg::HALF_STAGES].w : ks_buf_ff;
      ks_buf_in    = ks_buf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (advance) begin
         rsp_valid_in = chain[xcs_pkg::HALF_STAGES].valid;
         if (chain[xcs_pkg::HALF_STAGES].valid) begin
            ks_buf_in   = ks_now;
            rsp_byte_in = chain[xcs_pkg::HALF_STAGES].data ^
                          ks_now[chain[xcs_pkg::HALF_STAGES].pos];
            rsp_last_in = chain[xcs_pkg::HALF_STAGES].last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ks_buf_ff   <= ks_buf_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_out_last = rsp_last_ff;

endmodule

### sim/xtea_ctr_stream_cipher_unit_tb.sv
// testbench for the xtea counter-mode stream cipher unit: directed and random packets checked against a predictor
`timescale 1ns / 100ps

module xtea_ctr_stream_cipher_unit_tb;

   localparam int LATENCY     = 2 * xcs_pkg::ROUNDS + 1;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_BYTES = 350;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } cipher_word_type;

   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           req_valid        = 1'b0;
   logic                           req_ready;
   logic [7:0]                     req_data_byte    = '0;
   logic [15:0]                    req_frame_number = '0;
   logic                           req_last_byte    = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready        = 1'b0;
   logic [7:0]                     rsp_out_byte;
   logic                           rsp_out_last;
   logic                           csr_psel         = 1'b0;
   logic                           csr_penable      = 1'b0;
   logic                           csr_pwrite       = 1'b0;
   logic [xcs_pkg::ADDR_WIDTH-1:0] csr_paddr        = '0;
   logic [31:0]                    csr_pwdata       = '0;
   logic [31:0]                    csr_prdata;
   logic                           csr_pready;

   // predictor state
   logic [31:0] key_model [xcs_pkg::KEY_WORDS];
   logic [3:0]  byte_pos;
   logic [31:0] block_idx;
   logic [15:0] frame_held;
   logic        in_packet;
   logic [7:0]  keystream [16];

   cipher_word_type expected_bytes[$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   bit              req_burst      = 1'b0;
   bit              rsp_burst      = 1'b0;
   int              rsp_stall_left = 0;

   xtea_ctr_stream_cipher_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_frame_number (req_frame_number),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_out_last     (rsp_out_last),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic int draw_wait(input bit burst);
      if (burst) begin
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   // full xtea encipher of one 64-bit pair under the modeled key
   function automatic logic [63:0] xtea_encipher(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] sum;
      sum = '0;
      for (int r = 0; r < xcs_pkg::ROUNDS; r++) begin
         a   = a + ((((b << 4) ^ (b >> 5)) + b) ^ (sum + key_model[sum[1:0]]));
         sum = sum + xcs_pkg::XTEA_DELTA;
         b   = b + ((((a << 4) ^ (a >> 5)) + a) ^ (sum + key_model[sum[12:11]]));
      end
      return {a, b};
   endfunction

   function automatic cipher_word_type cipher_byte(input logic [7:0] data,
                                                   input logic [15:0] frame,
                                                   input logic last);
      cipher_word_type w;
      logic [63:0]     pair01;
      logic [63:0]     pair23;
      logic [31:0]     ks_word;
      if (!in_packet) begin
         frame_held = frame;
         block_idx  = '0;
         byte_pos   = '0;
      end
      // new counter block: frame, block index, then zeros
      if (byte_pos == 4'd0) begin
         pair01 = xtea_encipher({frame_held, block_idx[31:16]}, {block_idx[15:0], 16'h0000});
         pair23 = xtea_encipher(32'h0, 32'h0);
         for (int i = 0; i < 16; i++) begin
            case (i / 4)
               0: ks_word = pair01[63:32];
               1: ks_word = pair01[31:0];
               2: ks_word = pair23[63:32];
               default: ks_word = pair23[31:0];
            endcase
            keystream[i] = ks_word[8 * (i % 4) +: 8];
         end
      end
      w.out_byte = data ^ keystream[byte_pos];
      w.out_last = last;
      byte_pos   = byte_pos + 4'd1;
      if (byte_pos == 4'd0) begin
         block_idx = block_idx + 32'd1;
      end
      if (last) begin
         in_packet = 1'b0;
         byte_pos  = '0;
         block_idx = '0;
      end else begin
         in_packet = 1'b1;
      end
      return w;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch on %s: expected %0h, got %0h", field, exp_v, act_v);
      end
   endtask

   task automatic send_byte(input logic [7:0] data, input logic [15:0] frame, input logic last);
      int gap;
      gap = draw_wait(req_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data_byte    <= data;
      req_frame_number <= frame;
      req_last_byte    <= last;
      expected_bytes.push_back(cipher_byte(data, frame, last));
      do @(posedge clock); while (!req_ready);
   endtask

   // called right after an accept; waits until every word has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input xcs_pkg::reg_index_type idx,
                             input logic [31:0] value, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= xcs_pkg::ADDR_WIDTH'({idx, 2'b00});
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (write) begin
         key_model[idx] = value;
      end
   endtask

   task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3);
      logic [31:0] rdata;
      csr_access(1'b1, xcs_pkg::REG_KEY_WORD0, k0, rdata);
      csr_access(1'b1, xcs_pkg::REG_KEY_WORD1, k1, rdata);
      csr_access(1'b1, xcs_pkg::REG_KEY_WORD2, k2, rdata);
      csr_access(1'b1, xcs_pkg::REG_KEY_WORD3, k3, rdata);
      for (int i = 0; i < xcs_pkg::KEY_WORDS; i++) begin
         csr_access(1'b0, xcs_pkg::reg_index_type'(i), 32'h0, rdata);
         if (rdata !== key_model[i]) begin
            report_mismatch("key register readback", key_model[i], rdata);
         end
      end
   endtask

   // ragged packets carry a random last mark on any byte
   task automatic send_packet(input int len, input logic [15:0] frame, input bit close,
                              input bit ragged);
      logic last;
      for (int i = 0; i < len; i++) begin
         last = (close && i == len - 1) || (ragged && $urandom_range(0, 3) == 0);
         send_byte(8'($urandom_range(0, 255)), i == 0 ? frame : 16'($urandom_range(0, 65535)),
                   last);
      end
   endtask

   task automatic test_single_byte_packets();
      send_byte(8'h00, 16'h0000, 1'b1);
      send_byte(8'hff, 16'hffff, 1'b1);
      send_byte(8'h5a, 16'h8000, 1'b1);
      wait_idle();
   endtask

   // crosses a block boundary; frame on later bytes must be ignored
   task automatic test_block_boundary();
      load_key(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      for (int i = 0; i < 19; i++) begin
         send_byte(i % 2 ? 8'hff : 8'h00, i == 0 ? 16'h1234 : 16'($urandom_range(0, 65535)),
                   i == 18);
      end
      wait_idle();
   endtask

   // new key applies from the next block start only
   task automatic test_key_change_mid_block();
      load_key(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210);
      send_packet(5, 16'h00ff, 1'b0, 1'b0);
      wait_idle();
      load_key(32'h80000000, 32'h00000001, 32'h7fffffff, 32'hfffffffe);
      send_packet(14, 16'hbeef, 1'b1, 1'b0);
      wait_idle();
   endtask

   task automatic test_random_packets();
      int sent;
      int len;
      bit open;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: load_key(32'h0, 32'h0, 32'h0, 32'h0);
            1: load_key(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
            3: load_key(32'h80000000, 32'h00000001, 32'h7fffffff, 32'hfffffffe);
            default: load_key($urandom, $urandom, $urandom, $urandom);
         endcase
         sent = 0;
         while (sent < PHASE_BYTES) begin
            case ($urandom_range(0, 9))
               0: len = 1;
               1, 2, 3, 4, 5, 6: len = $urandom_range(2, 20);
               7, 8: len = $urandom_range(17, 48);
               default: len = $urandom_range(49, 120);
            endcase
            // the last packet of a phase is sometimes left open across the key change
            open = (sent + len >= PHASE_BYTES) && ($urandom_range(0, 1) == 1);
            req_burst = ($urandom_range(0, 4) == 0);
            send_packet(len, 16'($urandom_range(0, 65535)), !open, $urandom_range(0, 9) == 0);
            sent += len;
         end
         wait_idle();
      end
   endtask

   always @(posedge clock) begin : check_results
      cipher_word_type exp_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result word: out_byte %0h out_last %0b",
                        rsp_out_byte, rsp_out_last);
            end
         end else begin
            exp_word = expected_bytes.pop_front();
            if (rsp_out_byte !== exp_word.out_byte) begin
               report_mismatch("out_byte", 32'(exp_word.out_byte), 32'(rsp_out_byte));
            end
            if (rsp_out_last !== exp_word.out_last) begin
               report_mismatch("out_last", 32'(exp_word.out_last), 32'(rsp_out_last));
            end
         end
      end
   end

   // result side back-pressure, drawn after every accepted word
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left = 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            if ($urandom_range(0, 63) == 0) begin
               rsp_burst = !rsp_burst;
            end
            rsp_stall_left = draw_wait(rsp_burst);
            if (rsp_stall_left > 0) begin
               rsp_ready <= 1'b0;
            end
         end
      end else begin
         if (rsp_stall_left <= 1) begin
            rsp_ready <= 1'b1;
         end
         rsp_stall_left--;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < xcs_pkg::KEY_WORDS; i++) begin
         key_model[i] = '0;
      end
      byte_pos   = '0;
      block_idx  = '0;
      frame_held = '0;
      in_packet  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_single_byte_packets();
      test_block_boundary();
      test_key_change_mid_block();
      test_random_packets();

      repeat (LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
